### design/pmfr_pkg.sv
// Package for the per-module frame reassembly tracker.
// Holds the request and result types, action codes and fixed constants.
// No dependencies.
package pmfr_pkg;

    typedef enum logic [2:0] {
        ACT_SHORT      = 3'd0,
        ACT_BAD_MODULE = 3'd1,
        ACT_DROPPED    = 3'd2,
        ACT_APPENDED   = 3'd3,
        ACT_STARTED    = 3'd4
    } t_action;

    localparam logic [15:0] MIN_DGRAM_LENGTH     = 16'd100;
    localparam logic [7:0]  BODY_SEGMENTS_RESET  = 8'd15;
    localparam logic        REG_BODY_SEGMENTS    = 1'b0;

    typedef struct packed {
        logic [15:0] datagram_length;
        logic [7:0]  module_id;
        logic [15:0] frame_serial;
        logic [7:0]  segment_serial;
    } t_request;

    typedef struct packed {
        t_action     action;
        logic        emit_valid;
        logic [7:0]  emit_module;
        logic [15:0] emit_serial;
        logic [7:0]  emit_count;
        logic        emit_complete;
        logic [31:0] frames_total;
    } t_result;

endpackage

### design/pmfr_core.sv
// Per-module frame table and the decision logic for one request.
// Updates the table and the emitted-frame total when a request advances.
// Depends on pmfr_pkg.
module pmfr_core #(
    parameter int NUM_MODULES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  pmfr_pkg::t_request i_req,
    input  logic [7:0]         i_body_segments,
    output pmfr_pkg::t_result  o_res
);

    localparam int MW = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;

    logic [NUM_MODULES-1:0] r_open;
    logic [15:0]            r_serial [NUM_MODULES];
    logic [7:0]             r_count  [NUM_MODULES];
    logic [31:0]            r_total;

    logic [MW-1:0] idx;
    logic          in_range;
    logic [8:0]    full;
    logic          cur_open;
    logic [15:0]   cur_serial;
    logic [7:0]    cur_count;
    logic [7:0]    inc_count;
    logic          emit;
    logic          wr_open;
    logic          n_open_bit;
    logic          wr_entry;
    logic          wr_serial;
    logic [7:0]    n_count;

    always_comb begin
        idx        = i_req.module_id[MW-1:0];
        in_range   = {1'b0, i_req.module_id} < 9'(NUM_MODULES);
        full       = {1'b0, i_body_segments} + 9'd1;
        cur_open   = r_open[idx];
        cur_serial = r_serial[idx];
        cur_count  = r_count[idx];
        inc_count  = (cur_count == 8'hFF) ? 8'hFF : cur_count + 8'd1;

        o_res      = '0;
        o_res.action = pmfr_pkg::ACT_SHORT;
        emit       = 1'b0;
        wr_open    = 1'b0;
        n_open_bit = 1'b0;
        wr_entry   = 1'b0;
        wr_serial  = 1'b0;
        n_count    = cur_count;

        if (i_req.datagram_length < pmfr_pkg::MIN_DGRAM_LENGTH) begin
            o_res.action = pmfr_pkg::ACT_SHORT;
        end else if (!in_range) begin
            o_res.action = pmfr_pkg::ACT_BAD_MODULE;
        end else if (i_req.segment_serial == 8'd0) begin
            emit = cur_open;
            o_res.emit_count    = cur_count;
            o_res.emit_complete = ({1'b0, cur_count} == full);
            wr_open    = 1'b1;
            n_open_bit = 1'b1;
            wr_entry   = 1'b1;
            wr_serial  = 1'b1;
            n_count    = 8'd1;
            o_res.action = pmfr_pkg::ACT_STARTED;
        end else if (!cur_open) begin
            o_res.action = pmfr_pkg::ACT_DROPPED;
        end else if (i_req.frame_serial == cur_serial) begin
            wr_entry = 1'b1;
            n_count  = inc_count;
            if ({1'b0, inc_count} == full) begin
                emit       = 1'b1;
                wr_open    = 1'b1;
                n_open_bit = 1'b0;
            end
            o_res.emit_count    = inc_count;
            o_res.emit_complete = 1'b1;
            o_res.action = pmfr_pkg::ACT_APPENDED;
        end else begin
            emit       = 1'b1;
            wr_open    = 1'b1;
            n_open_bit = 1'b0;
            o_res.emit_count    = cur_count;
            o_res.emit_complete = ({1'b0, cur_count} == full);
            o_res.action = pmfr_pkg::ACT_DROPPED;
        end

        o_res.emit_valid = emit;
        if (emit) begin
            o_res.emit_module = i_req.module_id;
            o_res.emit_serial = cur_serial;
        end else begin
            o_res.emit_count    = 8'd0;
            o_res.emit_complete = 1'b0;
        end
        o_res.frames_total = r_total + 32'(emit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= '0;
            r_total <= '0;
        end else if (i_advance) begin
            r_total <= o_res.frames_total;
            if (wr_open) begin
                r_open[idx] <= n_open_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && wr_entry) begin
            r_count[idx] <= n_count;
            if (wr_serial) begin
                r_serial[idx] <= i_req.frame_serial;
            end
        end
    end

endmodule

### design/per_module_frame_reassembly.sv
// Per-module frame reassembly tracker, top level.
// Input channel takes one datagram header per request: length, module id,
// frame serial and segment serial. Output channel returns one result per
// request: action, the frame handed on (if any) and the running total of
// frames handed on. Both channels use valid/ready.
// A request passes through the input register, the table lookup and update,
// and the result register.
// Throughput: one request per cycle while the receiver does not stall; the
// per-module table is read and written between the input and result registers.
// When the receiver stalls, the result register holds and the input register
// fills; the input side stops only once both are full.
// Reset clears all open-frame flags, the frame total and the valid flags of
// both pipeline registers, and sets body_segments to 15. body_segments is
// written via the APB port at byte address 0; the user must write it only
// while the block is idle (not enforced). Depends on pmfr_pkg and pmfr_core.
module per_module_frame_reassembly #(
    parameter int NUM_MODULES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_datagram_length,
    input  logic [7:0]  i_module_id,
    input  logic [15:0] i_frame_serial,
    input  logic [7:0]  i_segment_serial,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_action,
    output logic        o_emit_valid,
    output logic [7:0]  o_emit_module,
    output logic [15:0] o_emit_serial,
    output logic [7:0]  o_emit_count,
    output logic        o_emit_complete,
    output logic [31:0] o_frames_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               r_in_valid;
    pmfr_pkg::t_request r_in_req;
    logic               r_out_valid;
    pmfr_pkg::t_result  r_out_res;
    logic [7:0]         r_body;
    logic               advance;
    pmfr_pkg::t_result  n_res;

    assign pready     = 1'b1;
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        if (paddr[2] == pmfr_pkg::REG_BODY_SEGMENTS) begin
            prdata = {24'd0, r_body};
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body <= pmfr_pkg::BODY_SEGMENTS_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == pmfr_pkg::REG_BODY_SEGMENTS) begin
            r_body <= pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_req.datagram_length <= i_datagram_length;
            r_in_req.module_id       <= i_module_id;
            r_in_req.frame_serial    <= i_frame_serial;
            r_in_req.segment_serial  <= i_segment_serial;
        end
        if (advance) begin
            r_out_res <= n_res;
        end
    end

    pmfr_core #(
        .NUM_MODULES(NUM_MODULES)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_req          (r_in_req),
        .i_body_segments(r_body),
        .o_res          (n_res)
    );

    assign o_out_valid     = r_out_valid;
    assign o_action        = r_out_res.action;
    assign o_emit_valid    = r_out_res.emit_valid;
    assign o_emit_module   = r_out_res.emit_module;
    assign o_emit_serial   = r_out_res.emit_serial;
    assign o_emit_count    = r_out_res.emit_count;
    assign o_emit_complete = r_out_res.emit_complete;
    assign o_frames_total  = r_out_res.frames_total;

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_emit_valid |->
            o_emit_module == 8'd0 && o_emit_serial == 16'd0 &&
            o_emit_count == 8'd0 && !o_emit_complete)
        else $error("emit fields set without a frame handed on");

    a_drop_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_out_res.action == pmfr_pkg::ACT_SHORT ||
                        r_out_res.action == pmfr_pkg::ACT_BAD_MODULE) |->
            !o_emit_valid)
        else $error("rejected request handed on a frame");

    a_complete_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_emit_complete |->
            {1'b0, o_emit_count} == {1'b0, r_body} + 9'd1)
        else $error("complete frame with wrong count");

    a_append_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_emit_valid &&
            r_out_res.action == pmfr_pkg::ACT_APPENDED |-> o_emit_complete)
        else $error("append handed on an incomplete frame");

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(advance) && $past(r_out_valid) && $past(i_rst_n) |->
            r_out_res.frames_total ==
                $past(r_out_res.frames_total) + 32'(r_out_res.emit_valid))
        else $error("frame total out of step");

endmodule

### tb/pmfr_checker.sv
`timescale 1ns / 1ps
// Checker for the per-module frame reassembly tracker: watches the request,
// result and APB channels, predicts each result from its own frame table and
// compares field by field. Depends on pmfr_pkg.
module pmfr_checker #(
    parameter int NUM_MODULES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_datagram_length,
    input  logic [7:0]  i_module_id,
    input  logic [15:0] i_frame_serial,
    input  logic [7:0]  i_segment_serial,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_action,
    input  logic        i_emit_valid,
    input  logic [7:0]  i_emit_module,
    input  logic [15:0] i_emit_serial,
    input  logic [7:0]  i_emit_count,
    input  logic        i_emit_complete,
    input  logic [31:0] i_frames_total,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [2:0] BODY_SEGMENTS_ADDR = {pmfr_pkg::REG_BODY_SEGMENTS, 2'b00};

    logic [7:0]          body_segments;
    logic                frame_open    [NUM_MODULES];
    logic [15:0]         open_serial   [NUM_MODULES];
    logic [7:0]          segment_count [NUM_MODULES];
    logic [31:0]         emitted_total;
    pmfr_pkg::t_result   pending_results[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    function automatic void hand_on_frame(input int m, inout pmfr_pkg::t_result r);
        r.emit_valid    = 1'b1;
        r.emit_module   = 8'(m);
        r.emit_serial   = open_serial[m];
        r.emit_count    = segment_count[m];
        r.emit_complete = ({1'b0, segment_count[m]} == {1'b0, body_segments} + 9'd1);
        emitted_total   = emitted_total + 32'd1;
    endfunction

    function automatic pmfr_pkg::t_result predict_frame(input pmfr_pkg::t_request req);
        pmfr_pkg::t_result r;
        int                m;
        r = '0;
        m = int'(req.module_id);
        if (req.datagram_length < pmfr_pkg::MIN_DGRAM_LENGTH) begin
            r.action = pmfr_pkg::ACT_SHORT;
        end else if (m >= NUM_MODULES) begin
            r.action = pmfr_pkg::ACT_BAD_MODULE;
        end else if (req.segment_serial == 8'd0) begin
            if (frame_open[m]) begin
                hand_on_frame(m, r);
            end
            frame_open[m]    = 1'b1;
            open_serial[m]   = req.frame_serial;
            segment_count[m] = 8'd1;
            r.action         = pmfr_pkg::ACT_STARTED;
        end else if (!frame_open[m]) begin
            r.action = pmfr_pkg::ACT_DROPPED;
        end else if (req.frame_serial == open_serial[m]) begin
            if (segment_count[m] != 8'hFF) begin
                segment_count[m] = segment_count[m] + 8'd1;
            end
            if ({1'b0, segment_count[m]} == {1'b0, body_segments} + 9'd1) begin
                hand_on_frame(m, r);
                frame_open[m] = 1'b0;
            end
            r.action = pmfr_pkg::ACT_APPENDED;
        end else begin
            hand_on_frame(m, r);
            frame_open[m] = 1'b0;
            r.action      = pmfr_pkg::ACT_DROPPED;
        end
        r.frames_total = emitted_total;
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        pmfr_pkg::t_result  want;
        pmfr_pkg::t_request req;
        if (!i_rst_n) begin
            body_segments = pmfr_pkg::BODY_SEGMENTS_RESET;
            for (int m = 0; m < NUM_MODULES; m++) begin
                frame_open[m] = 1'b0;
            end
            emitted_total = '0;
            pending_results.delete();
            o_pending = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request pending, frames_total",
                                    i_frames_total, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_action !== want.action)
                        report_mismatch("action", 32'(i_action), 32'(want.action));
                    if (i_emit_valid !== want.emit_valid)
                        report_mismatch("emit_valid", 32'(i_emit_valid), 32'(want.emit_valid));
                    if (i_emit_module !== want.emit_module)
                        report_mismatch("emit_module", 32'(i_emit_module),
                                        32'(want.emit_module));
                    if (i_emit_serial !== want.emit_serial)
                        report_mismatch("emit_serial", 32'(i_emit_serial),
                                        32'(want.emit_serial));
                    if (i_emit_count !== want.emit_count)
                        report_mismatch("emit_count", 32'(i_emit_count), 32'(want.emit_count));
                    if (i_emit_complete !== want.emit_complete)
                        report_mismatch("emit_complete", 32'(i_emit_complete),
                                        32'(want.emit_complete));
                    if (i_frames_total !== want.frames_total)
                        report_mismatch("frames_total", i_frames_total, want.frames_total);
                end
            end
            if (i_in_valid && i_in_ready) begin
                req.datagram_length = i_datagram_length;
                req.module_id       = i_module_id;
                req.frame_serial    = i_frame_serial;
                req.segment_serial  = i_segment_serial;
                pending_results.push_back(predict_frame(req));
            end
            if (i_psel && i_penable && i_pready && i_paddr == BODY_SEGMENTS_ADDR) begin
                if (i_pwrite) begin
                    body_segments = i_pwdata[7:0];
                end else if (i_prdata !== {24'd0, body_segments}) begin
                    report_mismatch("body_segments readback", i_prdata, {24'd0, body_segments});
                end
            end
            o_pending = pending_results.size();
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the per-module frame reassembly tracker: clock, reset,
// request and result traffic, register writes and verdict.
// Depends on pmfr_pkg, per_module_frame_reassembly and pmfr_checker.
module testbench;

    localparam int NUM_MODULES  = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 80;
    localparam logic [2:0] BODY_SEGMENTS_ADDR = {pmfr_pkg::REG_BODY_SEGMENTS, 2'b00};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] datagram_length;
    logic [7:0]  module_id;
    logic [15:0] frame_serial;
    logic [7:0]  segment_serial;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  action;
    logic        emit_valid;
    logic [7:0]  emit_module;
    logic [15:0] emit_serial;
    logic [7:0]  emit_count;
    logic        emit_complete;
    logic [31:0] frames_total;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    bit          tx_idle;
    bit          rx_idle;
    int          hold_req;
    int          hold_ack;
    int          body_cfg;
    int          next_seg   [NUM_MODULES];
    logic [15:0] cur_serial [NUM_MODULES];

    per_module_frame_reassembly #(
        .NUM_MODULES(NUM_MODULES)
    ) uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_datagram_length(datagram_length),
        .i_module_id      (module_id),
        .i_frame_serial   (frame_serial),
        .i_segment_serial (segment_serial),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_action         (action),
        .o_emit_valid     (emit_valid),
        .o_emit_module    (emit_module),
        .o_emit_serial    (emit_serial),
        .o_emit_count     (emit_count),
        .o_emit_complete  (emit_complete),
        .o_frames_total   (frames_total),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    pmfr_checker #(
        .NUM_MODULES(NUM_MODULES)
    ) frame_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_datagram_length(datagram_length),
        .i_module_id      (module_id),
        .i_frame_serial   (frame_serial),
        .i_segment_serial (segment_serial),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_action         (action),
        .i_emit_valid     (emit_valid),
        .i_emit_module    (emit_module),
        .i_emit_serial    (emit_serial),
        .i_emit_count     (emit_count),
        .i_emit_complete  (emit_complete),
        .i_frames_total   (frames_total),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_prdata         (prdata),
        .i_pready         (pready),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : result_sink
        int stall;
        out_ready = 1'b0;
        hold_ack  = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_req != hold_ack) begin
                stall    = LONG_HOLD;
                hold_ack = hold_req;
            end else begin
                stall = rx_idle ? $urandom_range(0, 18) : 0;
            end
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    function automatic logic [15:0] good_length();
        case ($urandom_range(0, 15))
            0:       return pmfr_pkg::MIN_DGRAM_LENGTH;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(int'(pmfr_pkg::MIN_DGRAM_LENGTH), 65535));
        endcase
    endfunction

    task automatic send_request(input logic [15:0] len, input logic [7:0] mod,
                                input logic [15:0] serial, input logic [7:0] seg);
        int gap;
        gap = tx_idle ? $urandom_range(0, 18) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        datagram_length <= len;
        module_id       <= mod;
        frame_serial    <= serial;
        segment_serial  <= seg;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= BODY_SEGMENTS_ADDR;
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_body_segments(input logic [7:0] value);
        drain_results();
        apb_access(1'b1, value);
        apb_access(1'b0, 8'd0);
        body_cfg = int'(value);
    endtask

    task automatic send_random_requests(input int count);
        int pick;
        int m;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_request(16'($urandom_range(0, int'(pmfr_pkg::MIN_DGRAM_LENGTH) - 1)),
                             8'($urandom), 16'($urandom), 8'($urandom));
            end else if (pick < 14) begin
                send_request(good_length(), 8'($urandom_range(NUM_MODULES, 255)),
                             16'($urandom), 8'($urandom));
            end else begin
                m = (pick < 80) ? $urandom_range(0, 3) : $urandom_range(0, NUM_MODULES - 1);
                if (pick < 20) begin
                    send_request(good_length(), 8'(m), 16'($urandom),
                                 8'($urandom_range(1, 255)));
                    next_seg[m] = 0;
                end else if (next_seg[m] == 0 || next_seg[m] > body_cfg
                             || $urandom_range(0, 24) == 0) begin
                    cur_serial[m] = 16'($urandom);
                    send_request(good_length(), 8'(m), cur_serial[m], 8'd0);
                    next_seg[m] = 1;
                end else if ($urandom_range(0, 24) == 0) begin
                    send_request(good_length(), 8'(m),
                                 cur_serial[m] ^ 16'($urandom_range(1, 65535)),
                                 8'(next_seg[m]));
                    next_seg[m] = 0;
                end else begin
                    send_request(good_length(), 8'(m), cur_serial[m], 8'(next_seg[m]));
                    next_seg[m] = (next_seg[m] == body_cfg) ? 0 : next_seg[m] + 1;
                end
            end
        end
    endtask

    task automatic send_full_frame(input int m);
        logic [15:0] serial;
        serial = 16'($urandom);
        for (int k = 0; k <= body_cfg; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_request(16'($urandom_range(0, int'(pmfr_pkg::MIN_DGRAM_LENGTH) - 1)),
                             8'(m), 16'($urandom), 8'($urandom));
            end
            send_request(good_length(), 8'(m), serial, 8'(k));
        end
        next_seg[m] = 0;
    endtask

    initial begin : stimulus
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        datagram_length = '0;
        module_id       = '0;
        frame_serial    = '0;
        segment_serial  = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        tx_idle         = 1'b1;
        rx_idle         = 1'b1;
        hold_req        = 0;
        body_cfg        = int'(pmfr_pkg::BODY_SEGMENTS_RESET);
        for (int m = 0; m < NUM_MODULES; m++) begin
            next_seg[m]   = 0;
            cur_serial[m] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apb_access(1'b0, 8'd0);
        set_body_segments(8'd2);

        send_request(16'd0, 8'd0, 16'd0, 8'd0);
        send_request(16'd99, 8'd3, 16'hFFFF, 8'd0);
        send_request(16'd99, 8'd255, 16'h5A5A, 8'd255);
        send_request(pmfr_pkg::MIN_DGRAM_LENGTH, 8'd16, 16'd0, 8'd0);
        send_request(16'hFFFF, 8'd255, 16'hFFFF, 8'd255);
        send_request(pmfr_pkg::MIN_DGRAM_LENGTH, 8'd0, 16'h1234, 8'd5);
        send_request(16'hFFFF, 8'd0, 16'hFFFF, 8'd0);
        send_request(pmfr_pkg::MIN_DGRAM_LENGTH, 8'd0, 16'hFFFF, 8'd1);
        send_request(16'd4000, 8'd0, 16'hFFFF, 8'd2);
        send_request(16'd500, 8'd15, 16'd0, 8'd0);
        send_request(16'd500, 8'd15, 16'd1, 8'd0);
        send_request(16'd500, 8'd15, 16'd2, 8'd1);
        send_request(16'd500, 8'd15, 16'd1, 8'd1);
        send_request(16'd800, 8'd7, 16'h8000, 8'd0);
        send_request(16'd800, 8'd7, 16'h8000, 8'd255);
        send_request(16'd50, 8'd7, 16'h0001, 8'd0);
        send_request(16'd800, 8'd7, 16'h8000, 8'd128);
        send_request(16'd800, 8'd7, 16'h8000, 8'd1);

        set_body_segments(8'd1);
        send_random_requests(250);

        set_body_segments(8'd254);
        tx_idle = 1'b0;
        send_full_frame(12);
        send_random_requests(60);

        set_body_segments(pmfr_pkg::BODY_SEGMENTS_RESET);
        rx_idle  = 1'b1;
        hold_req = hold_req + 1;
        send_random_requests(100);
        tx_idle = 1'b1;
        drain_results();
        send_random_requests(100);

        set_body_segments(8'($urandom_range(3, 8)));
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_random_requests(250);

        set_body_segments(8'($urandom_range(1, 6)));
        tx_idle = 1'b1;
        send_random_requests(150);

        drain_results();
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
